### src/fpa_pkg.sv
// Package for the fixed-point ALU: command codes, widths, shared types.
// No dependencies.
package fpa_pkg;
  localparam int DataWidth = 32;
  localparam int FractionBitsDefault = 8;

  typedef enum logic [3:0] {
    CMD_ADD = 4'd0, CMD_SUB = 4'd1, CMD_MUL = 4'd2, CMD_DIV = 4'd3,
    CMD_MIN = 4'd4, CMD_MAX = 4'd5, CMD_TOINT = 4'd6, CMD_FROMINT = 4'd7,
    CMD_INC = 4'd8, CMD_DEC = 4'd9
  } cmd_t;

  typedef struct packed {
    logic                 vld;
    logic                 is_div;
    logic                 neg;
    logic                 dz;
    logic [DataWidth-1:0] other;
    logic [3:0]           flags;
  } ctl_t;
endpackage

### src/fpa_div_cell.sv
// One restoring-division cell: handles one quotient bit per cycle while en is high.
// Depends on fpa_pkg.
module fpa_div_cell import fpa_pkg::*; #(
  parameter int NumW = 40
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [DataWidth-1:0] div_in,
  input  logic [DataWidth:0]   rem_in,
  input  logic [NumW-1:0]      num_in,
  input  ctl_t                 ctl_in,
  output logic [DataWidth-1:0] div_out,
  output logic [DataWidth:0]   rem_out,
  output logic [NumW-1:0]      num_out,
  output ctl_t                 ctl_out,
  input  logic                 rst
);
  logic [DataWidth+1:0] trial;
  logic [DataWidth:0]   shifted;
  always_comb begin
    shifted = {rem_in[DataWidth-1:0], num_in[NumW-1]};
    trial = {1'b0, shifted} - {2'b0, div_in};
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.vld <= 1'b0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
    if (en) begin
      div_out <= div_in;
      if (!trial[DataWidth+1]) begin
        rem_out <= trial[DataWidth:0];
        num_out <= {num_in[NumW-2:0], 1'b1};
      end else begin
        rem_out <= shifted;
        num_out <= {num_in[NumW-2:0], 1'b0};
      end
    end
  end
endmodule

### src/fixed_point_alu_q24_8_unit.sv
// Fixed-point ALU, Q(32-F).F, top level.
// Every command takes the same path: stage 0, one chain of F+32 divider cells, output register.
// Throughput: one request per cycle; the chain stalls as a whole on output backpressure.
// Reset: rst clears valid bits only; payload registers are not reset.
// Depends on fpa_pkg and fpa_div_cell.
module fixed_point_alu_q24_8_unit import fpa_pkg::*; #(
  parameter int FRACTION_BITS = FractionBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // command[3:0], operand_a[35:4], operand_b[67:36], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // result, a_less, a_greater, a_equal, divide_by_zero, pad
);
  localparam int NumW = DataWidth + FRACTION_BITS;
  localparam int Cells = NumW;
  localparam int ProdW = 2 * DataWidth;

  logic en;
  assign en = m_tready || !m_tvalid;
  assign s_tready = en;

  logic [3:0] cmd;
  logic signed [DataWidth-1:0] a, b;
  assign cmd = s_tdata[3:0];
  assign a = s_tdata[35:4];
  assign b = s_tdata[67:36];

  // stage 0: decode, magnitudes, simple ops, register product
  logic [DataWidth-1:0] ma, mb, simple;
  logic lt, gt, eq;
  always_comb begin
    ma = a[DataWidth-1] ? DataWidth'(-a) : DataWidth'(a);
    mb = b[DataWidth-1] ? DataWidth'(-b) : DataWidth'(b);
    lt = a < b;
    gt = a > b;
    eq = a == b;
    simple = '0;
    unique case (cmd)
      CMD_ADD:     simple = a + b;
      CMD_SUB:     simple = a - b;
      CMD_MIN:     simple = lt ? a : b;
      CMD_MAX:     simple = gt ? a : b;
      CMD_TOINT:   simple = DataWidth'(a >>> FRACTION_BITS);
      CMD_FROMINT: simple = DataWidth'(a <<< FRACTION_BITS);
      CMD_INC:     simple = a + 1;
      CMD_DEC:     simple = a - 1;
      default:     simple = '0;
    endcase
  end

  ctl_t c0;
  logic [DataWidth-1:0] d0;
  logic [NumW-1:0] n0;
  logic [ProdW-1:0] prod;
  logic is_mul0;
  always_ff @(posedge clk) begin
    if (rst) begin
      c0.vld <= 1'b0;
    end else if (en) begin
      c0.vld <= s_tvalid;
    end
    if (en) begin
      c0.is_div <= cmd == CMD_DIV;
      c0.neg    <= a[DataWidth-1] ^ b[DataWidth-1];
      c0.dz     <= (cmd == CMD_DIV) && (b == '0);
      c0.other  <= simple;
      c0.flags  <= {lt, gt, eq, 1'b0};
      is_mul0   <= cmd == CMD_MUL;
      prod      <= ma * mb;
      d0        <= mb;
      n0        <= {ma, FRACTION_BITS'(0)};
    end
  end

  // multiply result folds into "other" on entry to the chain
  logic [DataWidth-1:0] mres;
  ctl_t c0m;
  always_comb begin
    mres = DataWidth'(prod >> FRACTION_BITS);
    c0m = c0;
    if (is_mul0) c0m.other = c0.neg ? DataWidth'(-mres) : mres;
  end

  ctl_t                 ctl [Cells+1];
  logic [DataWidth-1:0] dv  [Cells+1];
  logic [DataWidth:0]   rm  [Cells+1];
  logic [NumW-1:0]      nm  [Cells+1];
  assign ctl[0] = c0m;
  assign dv[0] = d0;
  assign rm[0] = '0;
  assign nm[0] = n0;

  for (genvar i = 0; i < Cells; i++) begin : g_cell
    fpa_div_cell #(.NumW(NumW)) u_cell (
      .clk(clk), .en(en),
      .div_in(dv[i]), .rem_in(rm[i]), .num_in(nm[i]), .ctl_in(ctl[i]),
      .div_out(dv[i+1]), .rem_out(rm[i+1]), .num_out(nm[i+1]), .ctl_out(ctl[i+1]),
      .rst(rst)
    );
  end

  ctl_t ce;
  logic [DataWidth-1:0] q, res;
  always_comb begin
    ce = ctl[Cells];
    q = DataWidth'(nm[Cells]);
    if (!ce.is_div) res = ce.other;
    else if (ce.dz) res = '0;
    else res = ce.neg ? DataWidth'(-q) : q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= ce.vld;
    end
    if (en) begin
      m_tdata <= {4'b0, ce.dz, ce.flags[1], ce.flags[2], ce.flags[3], res};
    end
  end
endmodule
